// ===== hdl/cpfc_pkg.sv =====
// Package for the capture pixel format converter: payload structs, palette mode codes,
// register indexes and the constant expansion and coefficient tables.
// Depends on nothing; imported by capture_pixel_format_converter_top.
package cpfc_pkg;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_out_t;

	typedef enum logic [2:0] {
		MODE_YCBCR  = 3'd0,
		MODE_RGB555 = 3'd1,
		MODE_RGB565 = 3'd2,
		MODE_RGB24  = 3'd3,
		MODE_PASS   = 3'd4
	} palette_mode_t;

	localparam int REG_INDEX_W = 1;
	localparam int REG_DATA_W  = 3;
	localparam logic [REG_INDEX_W-1:0] REG_PALETTE_MODE  = 1'b0;
	localparam logic [REG_INDEX_W-1:0] REG_SWAP_RED_BLUE = 1'b1;

	localparam int Y_LOW     = 16;
	localparam int Y_HIGH    = 235;
	localparam int Y_SPAN    = 219;
	localparam int C_MID     = 128;
	localparam int C_LOW     = 16;
	localparam int C_HIGH    = 240;
	localparam int C_SPAN    = 112;
	localparam int C_MAX     = 127;
	localparam int K_RV      = 1402;
	localparam int K_GU      = 344;
	localparam int K_GV      = 714;
	localparam int K_BU      = 1772;
	localparam int COEF_SCALE = 1000;

	typedef logic [7:0] luma_lut_t [256];
	typedef logic signed [8:0] coef_lut_t [256];

	// Luma 16..235 stretched to 0..255, truncated.
	function automatic luma_lut_t build_luma_lut();
		luma_lut_t lut;
		int v;
		for (int i = 0; i < 256; i++) begin
			if (i <= Y_LOW)
				v = 0;
			else if (i >= Y_HIGH)
				v = 255;
			else
				v = (255 * (i - Y_LOW)) / Y_SPAN;
			lut[8'(i)] = 8'(v);
		end
		return lut;
	endfunction

	function automatic int chroma_of(int i);
		int v;
		if (i <= C_LOW)
			v = -C_MAX;
		else if (i >= C_HIGH)
			v = C_MAX;
		else
			v = (C_MAX * (i - C_MID)) / C_SPAN;
		return v;
	endfunction

	// Coefficient product indexed by the raw chroma byte, truncated toward zero.
	function automatic coef_lut_t build_coef_lut(int k);
		coef_lut_t lut;
		int v;
		for (int i = 0; i < 256; i++) begin
			v = (k * chroma_of(i)) / COEF_SCALE;
			lut[8'(i)] = 9'(v);
		end
		return lut;
	endfunction

	localparam luma_lut_t LUMA_LUT = build_luma_lut();
	localparam coef_lut_t RV_LUT   = build_coef_lut(K_RV);
	localparam coef_lut_t GU_LUT   = build_coef_lut(K_GU);
	localparam coef_lut_t GV_LUT   = build_coef_lut(K_GV);
	localparam coef_lut_t BU_LUT   = build_coef_lut(K_BU);

endpackage

// ===== hdl/capture_pixel_format_converter_top.sv =====
// Top level of the capture pixel format converter: configuration registers, input register,
// conversion logic and result register. Depends on cpfc_pkg.
//
// Converts one pixel per clock to 24-bit RGB. An item is taken on every edge where start is
// high; busy is always low. The result passes through the input register and then the result
// register, with result_valid high for exactly one cycle; the receiver cannot stall
// and must take it then. palette_mode and swap_red_blue are sampled as each item leaves the
// input register, so write them only while no item is in flight.
module capture_pixel_format_converter_top
	import cpfc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  pixel_in_t              pixel,
	output logic                   result_valid,
	output pixel_out_t             result,
	input  logic                   wr_en,
	input  logic [REG_INDEX_W-1:0] wr_index,
	input  logic [REG_DATA_W-1:0]  wr_data
);

	palette_mode_t palette_mode_q;
	logic          swap_red_blue_q;
	logic          valid_s1;
	pixel_in_t     pix_s1;
	pixel_out_t    conv;

	logic [7:0]        y_val;
	logic signed [10:0] y_ext, r_sum, g_sum, b_sum;
	logic [7:0]        b0, b1, b2;

	function automatic logic [7:0] clamp8(logic signed [10:0] v);
		logic [7:0] res;
		if (v < 0)
			res = 8'd0;
		else if (v > 11'sd255)
			res = 8'd255;
		else
			res = v[7:0];
		return res;
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q  <= MODE_PASS;
			swap_red_blue_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PALETTE_MODE:  palette_mode_q  <= palette_mode_t'(wr_data);
				REG_SWAP_RED_BLUE: swap_red_blue_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= start;
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			pix_s1 <= pixel;
		if (valid_s1)
			result <= conv;
	end

	assign b0 = pix_s1.first_byte;
	assign b1 = pix_s1.second_byte;
	assign b2 = pix_s1.third_byte;

	assign y_val = LUMA_LUT[b0];
	assign y_ext = 11'(y_val);
	assign r_sum = y_ext + 11'(RV_LUT[b2]);
	assign g_sum = y_ext - (11'(GU_LUT[b1]) + 11'(GV_LUT[b2]));
	assign b_sum = y_ext + 11'(BU_LUT[b1]);

	always_comb begin
		conv.red   = b0;
		conv.green = b1;
		conv.blue  = b2;
		case (palette_mode_q)
			MODE_YCBCR: begin
				conv.red   = clamp8(r_sum);
				conv.green = clamp8(g_sum);
				conv.blue  = clamp8(b_sum);
			end
			MODE_RGB555: begin
				conv.blue  = {b0[4:0], 3'b000};
				conv.green = {b1[1:0], b0[7:5], 3'b000};
				conv.red   = {b1[6:2], 3'b000};
			end
			MODE_RGB565: begin
				conv.blue  = {b0[4:0], 3'b000};
				conv.green = {b1[2:0], b0[7:5], 2'b00};
				conv.red   = {b1[7:3], 3'b000};
			end
			MODE_RGB24: begin
				// exchange first and third bytes when swap is set
				if (swap_red_blue_q) begin
					conv.red  = b2;
					conv.blue = b0;
				end
			end
			default: ;
		endcase
	end

endmodule
